>>> sv/string_period_tuner_core_macros.svh
// Assertion macros used by the tuner checker.
`ifndef STRING_PERIOD_TUNER_CORE_MACROS_SVH
`define STRING_PERIOD_TUNER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/spt_pkg.sv
// Shared types, constants and string tables for the period tuner.
package spt_pkg;

  localparam int PERIOD_W    = 16;
  localparam int WINDOW      = 32;
  localparam int WIN_SHIFT   = $clog2(WINDOW);
  localparam int DONE_W      = $clog2(WINDOW);
  localparam int SUM_W       = PERIOD_W + WIN_SHIFT;
  localparam int STRINGS     = 6;
  localparam int STR_W       = 3;
  localparam int TOL_W       = 8;
  localparam int CFG_W       = 16;

  localparam logic [DONE_W-1:0] LAST_PERIOD = DONE_W'(WINDOW - 1);

  // Center period counts in ticks: high E, B, G, D, A, low E.
  localparam logic [PERIOD_W-1:0] CENTER [STRINGS] =
    '{16'd189, 16'd253, 16'd318, 16'd425, 16'd568, 16'd758};
  // Boundaries between neighboring strings, rising.
  localparam logic [PERIOD_W-1:0] BOUNDARY [STRINGS-1] =
    '{16'd216, 16'd282, 16'd364, 16'd486, 16'd649};

  typedef enum logic [1:0] {
    ST_IN_TUNE   = 2'd0,
    ST_TOO_HIGH  = 2'd1,
    ST_TOO_LOW   = 2'd2,
    ST_NO_SIGNAL = 2'd3
  } tune_status_t;

  typedef enum logic {
    REG_TIMEOUT   = 1'b0,
    REG_TOLERANCE = 1'b1
  } cfg_reg_t;

  // Config write as seen by the front and back ends.
  typedef struct packed {
    logic             we;
    cfg_reg_t         index;
    logic [CFG_W-1:0] wdata;
  } cfg_wr_t;

  // Event word passed from front to back.
  typedef struct packed {
    logic                no_signal;
    logic [PERIOD_W-1:0] avg;
  } spt_evt_t;

  function automatic logic [STR_W-1:0] pick_string(input logic [PERIOD_W-1:0] avg);
    logic [STR_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < STRINGS - 1; i++) begin
      if (avg >= BOUNDARY[i]) begin
        idx = STR_W'(i + 1);
      end
    end
    return idx;
  endfunction

endpackage

>>> sv/spt_front.sv
// Front end: edge detect, period count, window sum and timeout.
module spt_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  spt_pkg::cfg_wr_t      cfg,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_signal_level,
  input  logic                  q_full,
  output logic                  q_push,
  output spt_pkg::spt_evt_t     q_data
);

  logic [spt_pkg::PERIOD_W-1:0] timeout_r;
  logic                         prev_r, prev_nxt;
  logic                         armed_r, armed_nxt;
  logic [spt_pkg::PERIOD_W-1:0] ticks_r, ticks_nxt;
  logic [spt_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [spt_pkg::DONE_W-1:0]   done_r, done_nxt;

  logic                         accept;
  logic                         rising;
  logic [spt_pkg::PERIOD_W-1:0] ticks_inc;
  logic [spt_pkg::SUM_W-1:0]    sum_add;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign rising    = !prev_r && in_signal_level;
  assign ticks_inc = (ticks_r == '1) ? ticks_r : ticks_r + 1'b1;
  assign sum_add   = sum_r + spt_pkg::SUM_W'(ticks_inc);

  always_comb begin
    prev_nxt  = in_signal_level;
    armed_nxt = armed_r;
    ticks_nxt = ticks_inc;
    sum_nxt   = sum_r;
    done_nxt  = done_r;
    q_push    = 1'b0;
    q_data    = '{no_signal: 1'b0, avg: sum_add[spt_pkg::SUM_W-1:spt_pkg::WIN_SHIFT]};
    if (ticks_inc > timeout_r) begin
      q_push    = 1'b1;
      q_data    = '{no_signal: 1'b1, avg: '0};
      ticks_nxt = '0;
      sum_nxt   = '0;
      done_nxt  = '0;
      armed_nxt = rising;
    end else if (rising && !armed_r) begin
      // first edge only arms; its partial interval is dropped
      armed_nxt = 1'b1;
      ticks_nxt = '0;
      sum_nxt   = '0;
      done_nxt  = '0;
    end else if (rising) begin
      ticks_nxt = '0;
      if (done_r == spt_pkg::LAST_PERIOD) begin
        q_push   = 1'b1;
        sum_nxt  = '0;
        done_nxt = '0;
      end else begin
        sum_nxt  = sum_add;
        done_nxt = done_r + 1'b1;
      end
    end
    q_push = q_push && accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= spt_pkg::PERIOD_W'(15616);
      prev_r    <= 1'b0;
      armed_r   <= 1'b0;
      ticks_r   <= '0;
      sum_r     <= '0;
      done_r    <= '0;
    end else begin
      if (cfg.we && cfg.index == spt_pkg::REG_TIMEOUT) begin
        timeout_r <= cfg.wdata[spt_pkg::PERIOD_W-1:0];
      end
      if (accept) begin
        prev_r  <= prev_nxt;
        armed_r <= armed_nxt;
        ticks_r <= ticks_nxt;
        sum_r   <= sum_nxt;
        done_r  <= done_nxt;
      end
    end
  end

endmodule

>>> sv/spt_fifo.sv
// Two-entry event queue between front and back ends.
module spt_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  spt_pkg::spt_evt_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output logic              rd_valid,
  output spt_pkg::spt_evt_t rd_data
);

  spt_pkg::spt_evt_t mem [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full     = count_r[1];
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({wr_en, rd_en})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> sv/spt_back.sv
// Back end: string pick, tolerance compare and result register.
module spt_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  spt_pkg::cfg_wr_t                  cfg,
  input  logic                              q_valid,
  input  spt_pkg::spt_evt_t                 q_data,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [spt_pkg::STR_W-1:0]         out_string_index,
  output logic [1:0]                        out_tune_status,
  output logic [spt_pkg::PERIOD_W-1:0]      out_average_period
);

  logic [spt_pkg::TOL_W-1:0]    tol_r;
  logic                         valid_r;
  logic [spt_pkg::STR_W-1:0]    idx_r, idx_nxt;
  spt_pkg::tune_status_t        status_r, status_nxt;
  logic [spt_pkg::PERIOD_W-1:0] avg_r, avg_nxt;

  logic [spt_pkg::PERIOD_W-1:0] center;
  logic [spt_pkg::PERIOD_W:0]   avg_plus, ctr_plus;

  assign q_pop    = q_valid && (!valid_r || !out_stall);
  assign idx_nxt  = q_data.no_signal ? '0 : spt_pkg::pick_string(q_data.avg);
  assign center   = spt_pkg::CENTER[idx_nxt];
  assign avg_plus = {1'b0, q_data.avg} + (spt_pkg::PERIOD_W + 1)'(tol_r);
  assign ctr_plus = {1'b0, center} + (spt_pkg::PERIOD_W + 1)'(tol_r);
  assign avg_nxt  = q_data.no_signal ? '0 : q_data.avg;

  always_comb begin
    if (q_data.no_signal) begin
      status_nxt = spt_pkg::ST_NO_SIGNAL;
    end else if (avg_plus < {1'b0, center}) begin
      status_nxt = spt_pkg::ST_TOO_HIGH;
    end else if ({1'b0, q_data.avg} > ctr_plus) begin
      status_nxt = spt_pkg::ST_TOO_LOW;
    end else begin
      status_nxt = spt_pkg::ST_IN_TUNE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= spt_pkg::TOL_W'(1);
      valid_r <= 1'b0;
    end else begin
      if (cfg.we && cfg.index == spt_pkg::REG_TOLERANCE) begin
        tol_r <= cfg.wdata[spt_pkg::TOL_W-1:0];
      end
      if (q_pop) begin
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      idx_r    <= idx_nxt;
      status_r <= status_nxt;
      avg_r    <= avg_nxt;
    end
  end

  assign out_valid          = valid_r;
  assign out_string_index   = idx_r;
  assign out_tune_status    = status_r;
  assign out_average_period = avg_r;

endmodule

>>> sv/string_period_tuner_core.sv
// Top level of the period-measuring string tuner.
//
//   port group  dir  handshake         payload
//   in_         in   in_valid/in_stall signal_level (1b), one timer tick
//   out_        out  out_valid/out_stall string_index (3b), tune_status (2b),
//                                      average_period (16b)
//   cfg_        in   cfg_we            cfg_index (1b), cfg_wdata (16b)
//
// Takes one tick word per cycle while in_stall is low; the front-end state
// update loops through its registers (increment, compare with timeout, add
// into the window sum). Results pass the queue, then the output register.
// rst_n is synchronous, active low; config returns to timeout 15616, tol 1.
// A stalled output backs up a two-entry queue; in_stall rises only when it fills.
module string_period_tuner_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_signal_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_string_index,
  output logic [1:0]  out_tune_status,
  output logic [15:0] out_average_period
);

  spt_pkg::cfg_wr_t  cfg;
  logic              q_push, q_full, q_pop, q_valid;
  spt_pkg::spt_evt_t q_wdata, q_rdata;

  // register writes fan out to whichever end owns the register
  assign cfg.we    = cfg_we;
  assign cfg.index = spt_pkg::cfg_reg_t'(cfg_index);
  assign cfg.wdata = cfg_wdata;

  // front: edge detect, period count, window sum, timeout
  spt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_signal_level (in_signal_level),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_wdata)
  );

  // event words wait here while the output is stalled
  spt_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_data  (q_wdata),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rdata)
  );

  // back: string lookup, tolerance band, output register
  spt_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .q_valid            (q_valid),
    .q_data             (q_rdata),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_string_index   (out_string_index),
    .out_tune_status    (out_tune_status),
    .out_average_period (out_average_period)
  );

endmodule

>>> sv/string_period_tuner_core_chk.sv
// Port-level checker for the tuner, bound to the top level.
`include "string_period_tuner_core_macros.svh"

module string_period_tuner_core_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_string_index,
  input logic [1:0]  out_tune_status,
  input logic [15:0] out_average_period
);

  `SPT_ASSERT_NOW(a_nosig_zero, out_valid && out_tune_status == spt_pkg::ST_NO_SIGNAL, out_string_index == 3'd0 && out_average_period == 16'd0, "no-signal word carries nonzero fields")
  `SPT_ASSERT_NOW(a_string_match, out_valid && out_tune_status != spt_pkg::ST_NO_SIGNAL, out_string_index == spt_pkg::pick_string(out_average_period), "string index disagrees with average")
  `SPT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_string_index) && $stable(out_tune_status) && $stable(out_average_period), "stalled result word changed")

endmodule

bind string_period_tuner_core string_period_tuner_core_chk u_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_string_index   (out_string_index),
  .out_tune_status    (out_tune_status),
  .out_average_period (out_average_period)
);

>>> tb/string_period_tuner_core_tb.sv
// Self-checking testbench for string_period_tuner_core: level ticks in, tuner readings checked.
`timescale 1ns / 1ps

module string_period_tuner_core_tb;

  // Bench-side constants. They are kept apart from the package so the bench
  // does not simply mirror the design's own tables.
  localparam int          WINDOW_PERIODS = 32;
  localparam int          WINDOW_SHIFT   = 5;
  localparam int unsigned LAST_STRING    = 5;
  localparam int          SETTLE_CYCLES  = 8;        // pad generously after the last result
  localparam int          HOLD_CYCLES    = 300;      // long receiver hold-off
  localparam int          DRAIN_LIMIT    = 5000;
  localparam int          MAX_REPORTS    = 40;
  localparam longint      LIMIT_CYCLES   = 200000;

  // One expected tuner reading.
  typedef struct {
    logic [2:0]            string_index;
    spt_pkg::tune_status_t status;
    logic [15:0]           period;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_signal_level = 1'b0;
  logic        out_stall = 1'b0;
  wire         in_stall;
  wire         out_valid;
  wire [2:0]   out_string_index;
  wire [1:0]   out_tune_status;
  wire [15:0]  out_average_period;

  string_period_tuner_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_signal_level   (in_signal_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_string_index  (out_string_index),
    .out_tune_status   (out_tune_status),
    .out_average_period(out_average_period)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Level ticks waiting to be driven, and readings waiting to come out.
  logic        level_q[$];
  reading_t    expected_readings[$];
  int unsigned ticks_queued = 0;
  int unsigned mismatches = 0;
  longint      cycle_count = 0;

  // Shadow of the tuner's registers and measurement state.
  logic [15:0] timeout_now = 16'd15616;
  logic [7:0]  tol_now = 8'd1;
  logic        pm_prev = 1'b0;
  logic        pm_armed = 1'b0;
  logic [15:0] pm_ticks = '0;
  int unsigned pm_sum = 0;
  int unsigned pm_done = 0;

  // Idling control for both sides.
  int unsigned gap_left = 0;
  int unsigned in_calm = 0;
  int unsigned stall_left = 0;
  int unsigned out_calm = 0;
  int unsigned hold_asks = 0;
  int unsigned holds_done = 0;
  int unsigned stall_roll;

  // ---------------------------------------------------------------- tables
  function automatic int unsigned center_of(input int unsigned s);
    case (s)
      0:       return 189;
      1:       return 253;
      2:       return 318;
      3:       return 425;
      4:       return 568;
      default: return 758;
    endcase
  endfunction

  // Lowest average that belongs to string s+1.
  function automatic int unsigned edge_above(input int unsigned s);
    case (s)
      0:       return 216;
      1:       return 282;
      2:       return 364;
      3:       return 486;
      default: return 649;
    endcase
  endfunction

  // ------------------------------------------------------------- predictor
  // Advance the shadow tuner by one tick; queue a reading if one is due.
  task automatic tuner_tick(input logic lvl);
    logic        rise;
    reading_t    r;
    int unsigned avg;
    int unsigned s;
    int unsigned c;
    rise = !pm_prev && lvl;
    pm_prev = lvl;
    if (pm_ticks != 16'hFFFF) pm_ticks = pm_ticks + 16'd1;
    if (pm_ticks > timeout_now) begin
      // no signal: clear the measurement, a coincident edge re-arms
      r.string_index = 3'd0;
      r.status = spt_pkg::ST_NO_SIGNAL;
      r.period = 16'd0;
      expected_readings.push_back(r);
      pm_ticks = '0;
      pm_sum = 0;
      pm_done = 0;
      pm_armed = rise;
    end else if (rise && !pm_armed) begin
      // first edge only arms; the partial interval before it is dropped
      pm_armed = 1'b1;
      pm_ticks = '0;
      pm_sum = 0;
      pm_done = 0;
    end else if (rise) begin
      pm_sum = pm_sum + pm_ticks;
      pm_ticks = '0;
      pm_done++;
      if (pm_done >= WINDOW_PERIODS) begin
        avg = (pm_sum >> WINDOW_SHIFT) & 32'hFFFF;
        s = 0;
        while (s < LAST_STRING && avg >= edge_above(s)) s++;
        c = center_of(s);
        r.string_index = 3'(s);
        r.period = 16'(avg);
        if (avg + tol_now < c) r.status = spt_pkg::ST_TOO_HIGH;
        else if (avg > c + tol_now) r.status = spt_pkg::ST_TOO_LOW;
        else r.status = spt_pkg::ST_IN_TUNE;
        expected_readings.push_back(r);
        pm_sum = 0;
        pm_done = 0;
      end
    end
  endtask

  // -------------------------------------------------------------- stimulus
  task automatic add_level(input logic lvl, input int unsigned n);
    repeat (n) begin
      level_q.push_back(lvl);
      ticks_queued++;
    end
  endtask

  // One rising-to-rising period of len ticks (len >= 2), random duty.
  task automatic add_pulse(input int unsigned len);
    int unsigned h;
    h = $urandom_range(1, len - 1);
    add_level(1'b1, h);
    add_level(1'b0, len - h);
  endtask

  // n ticks taken from bits, msb first.
  task automatic add_pattern(input logic [15:0] bits, input int n);
    for (int i = n - 1; i >= 0; i--) add_level(bits[i], 1);
  endtask

  // Clean window whose average is exactly target (target >= 3).
  // Flat low past the timeout first, so the window starts from a clean arm.
  task automatic add_exact_window(input int unsigned target);
    int unsigned j;
    add_level(1'b0, int'(timeout_now) + 1);
    // paired jitter keeps the sum at exactly 32 * target
    repeat (WINDOW_PERIODS / 2) begin
      j = $urandom_range(0, 1);
      add_pulse(target + j);
      add_pulse(target - j);
    end
    add_pulse(2);
  endtask

  // Mix of fast full windows, noise, flat stretches and broken windows.
  task automatic add_random_phase(input int unsigned n_ticks, input int unsigned n_windows);
    int unsigned start;
    int unsigned windows;
    int unsigned pmax;
    int unsigned flat_max;
    int unsigned base;
    int unsigned kind;
    start = ticks_queued;
    windows = 0;
    pmax = (timeout_now < 2) ? 2 : ((timeout_now < 6) ? timeout_now : 6);
    flat_max = (timeout_now < 100) ? timeout_now + 3 : 80;
    while (ticks_queued - start < n_ticks || windows < n_windows) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        base = $urandom_range(2, pmax);
        repeat ($urandom_range(WINDOW_PERIODS, WINDOW_PERIODS + 4))
          add_pulse(base + $urandom_range(0, 2));
        windows++;
      end else if (kind < 70) begin
        repeat ($urandom_range(4, 60)) add_level(1'($urandom), 1);
      end else if (kind < 85) begin
        add_level(1'($urandom), $urandom_range(1, flat_max));
      end else begin
        // window cut short, then a dead stretch
        repeat ($urandom_range(3, WINDOW_PERIODS - 1)) add_pulse($urandom_range(2, pmax));
        if (timeout_now <= 2000)
          add_level(1'($urandom), int'(timeout_now) + 1 + $urandom_range(0, 2));
        else
          repeat ($urandom_range(4, 20)) add_level(1'($urandom), 1);
      end
    end
  endtask

  task automatic set_reg(input spt_pkg::cfg_reg_t which, input logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= 16'($urandom);
    if (which == spt_pkg::REG_TIMEOUT) timeout_now = value;
    else tol_now = value[7:0];
    @(negedge clk);
  endtask

  // Tolerance write with junk in the unused upper byte.
  task automatic set_tol(input int unsigned tol);
    set_reg(spt_pkg::REG_TOLERANCE, {8'($urandom), 8'(tol)});
  endtask

  // Block idle: everything sent, every reading back, latency padded out.
  task automatic settle();
    while (level_q.size() != 0 || in_valid || expected_readings.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------- driver
  function automatic int unsigned next_in_gap();
    int unsigned r;
    r = $urandom_range(0, 999);
    if (in_calm != 0) begin
      in_calm--;
      return 0;
    end
    if (r < 3) in_calm = $urandom_range(100, 400);
    if (r < 750) return 0;
    if (r < 950) return $urandom_range(1, 3);
    if (r < 995) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        tuner_tick(in_signal_level);
        gap_left = next_in_gap();
      end
      // a held word stays untouched until it is taken
      if (!in_valid || !in_stall) begin
        if (gap_left == 0 && level_q.size() != 0) begin
          in_valid <= 1'b1;
          in_signal_level <= level_q.pop_front();
        end else begin
          if (gap_left != 0) gap_left--;
          in_valid <= 1'b0;
          in_signal_level <= 1'($urandom);
        end
      end
    end
  end

  // ------------------------------------------------------ receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (holds_done != hold_asks) begin
      // long hold-off: the result queue fills and the input backs up
      holds_done = hold_asks;
      stall_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (out_calm != 0) begin
      out_calm--;
      out_stall <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 999);
      if (stall_roll < 4) begin
        out_calm = $urandom_range(100, 500);
        out_stall <= 1'b0;
      end else if (stall_roll < 700) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        if (stall_roll < 960) stall_left = $urandom_range(0, 2);
        else if (stall_roll < 995) stall_left = $urandom_range(3, 10);
        else stall_left = $urandom_range(15, 40);
      end
    end
  end

  // --------------------------------------------------------------- monitor
  task automatic flag(input string what, input int unsigned want, input logic [15:0] got);
    if (mismatches < MAX_REPORTS)
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: unexpected word: expected none, got string %0d status %0d period %0d",
                   $time, out_string_index, out_tune_status, out_average_period);
        mismatches++;
      end else begin
        want = expected_readings.pop_front();
        if (out_string_index !== want.string_index)
          flag("string_index", want.string_index, 16'(out_string_index));
        if (out_tune_status !== want.status)
          flag("tune_status", want.status, 16'(out_tune_status));
        if (out_average_period !== want.period)
          flag("average_period", want.period, out_average_period);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // -------------------------------------------------------------- sequence
  initial begin
    int unsigned waited;
    int unsigned band_avg;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: arming edge and short periods at the reset settings.
    add_pattern(16'b0_1101_0010, 9);
    settle();
    // Zero timeout: every tick reports no signal, edges included.
    set_reg(spt_pkg::REG_TIMEOUT, 16'd0);
    set_tol(0);
    add_pattern(16'b1011, 4);
    settle();
    // Timeout of one: dead air reports every other tick.
    set_reg(spt_pkg::REG_TIMEOUT, 16'd1);
    add_pattern(16'b00_0110_1000, 10);
    settle();

    // Back to reset values, fast windows.
    set_reg(spt_pkg::REG_TIMEOUT, 16'd15616);
    set_tol(1);
    add_random_phase(150, 1);
    settle();

    // Widest settings: every fast window lands inside the band.
    set_reg(spt_pkg::REG_TIMEOUT, 16'hFFFF);
    set_tol(255);
    add_random_phase(100, 1);
    settle();

    // Exact averages against band edges around the high E center.
    set_reg(spt_pkg::REG_TIMEOUT, 16'd12);
    repeat (3) begin
      band_avg = $urandom_range(3, 6);
      set_tol(center_of(0) - band_avg - 1 + $urandom_range(0, 2));
      add_exact_window(band_avg);
      settle();
    end

    // Short timeout among fast windows, receiver holds off at the start.
    set_reg(spt_pkg::REG_TIMEOUT, 16'($urandom_range(8, 40)));
    set_tol($urandom_range(0, 255));
    hold_asks++;
    add_random_phase(150, 1);
    settle();

    // Timeout of one: readings nearly every other tick, another hold-off.
    set_reg(spt_pkg::REG_TIMEOUT, 16'd1);
    set_tol($urandom_range(0, 255));
    hold_asks++;
    add_random_phase(120, 0);
    settle();

    set_reg(spt_pkg::REG_TIMEOUT, 16'($urandom_range(20, 200)));
    set_tol($urandom_range(0, 255));
    add_random_phase(150, 1);
    settle();

    set_reg(spt_pkg::REG_TIMEOUT, 16'd0);
    set_tol(255);
    add_random_phase(60, 0);

    // Wind down: all words sent, then give the readings a bounded time.
    while (level_q.size() != 0 || in_valid) @(negedge clk);
    waited = 0;
    while (expected_readings.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_readings.size() != 0) begin
      $display("%0t: %0d expected readings never arrived", $time, expected_readings.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
